// ===== hw/rtl/fsst8_pkg.sv =====
// ----------------------------------------------------------------------------
// fsst8 package
// shared constants and types for the symbol table loader and decoder
// ----------------------------------------------------------------------------
package fsst8_pkg;

   localparam int MAX_SYMBOL_LEN = 8;
   localparam int MAX_SYMBOLS    = 255;
   localparam int MAX_BODY_BYTES = 2049;

   localparam logic [7:0] ESC_CODE = 8'hFF;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_BODY  = 3'd1,
      ST_HIST  = 3'd2,
      ST_DATA  = 3'd3,
      ST_TRUNC = 3'd4,
      ST_CODE  = 3'd5,
      ST_LONG  = 3'd6,
      ST_NOTAB = 3'd7
   } status_type;

   // symbol store write request from the loader
   typedef struct packed {
      logic       en;
      logic [7:0] code;
      logic [2:0] off;
      logic [3:0] len;
      logic [7:0] data;
   } sym_wr_type;

endpackage

// ===== hw/rtl/fsst8_table_load_and_decode_top.sv =====
// ----------------------------------------------------------------------------
// fsst8 table load and decode top
// loads a serialized symbol table and decodes compressed value bytes
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid req_ready req_func req_in_byte req_last
//  rsp     | out       | rsp_valid rsp_ready rsp_out_bytes ... rsp_end_of_value
//
// one transfer per cycle while req_ready is high; a value byte reads the symbol
// store in stage one and the registered symbol is masked and length checked in
// stage two; a three-deep output queue keeps req open at full rate while rsp
// drains, and closes it while rsp stalls
// reset clears all control state; the symbol memory is not cleared
// table writes land in the store before any later read is issued, so no forwarding is needed
module fsst8_table_load_and_decode_top #(
   parameter int MAX_SYMBOL_LEN = fsst8_pkg::MAX_SYMBOL_LEN,
   parameter int MAX_SYMBOLS    = fsst8_pkg::MAX_SYMBOLS,
   parameter int MAX_BODY_BYTES = fsst8_pkg::MAX_BODY_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [7:0]                  req_in_byte,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [8*MAX_SYMBOL_LEN-1:0] rsp_out_bytes,
   output logic [3:0]                  rsp_out_count,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_is_table,
   output logic                        rsp_end_of_value
);
   localparam int W  = 8 * MAX_SYMBOL_LEN;
   localparam int QD = 3;

   fsst8_pkg::sym_wr_type wr;
   logic       acc, tab_take, ld_done, tab_valid;
   logic [2:0] ld_status;
   logic [7:0] sym_total;
   logic [W-1:0] rd_bytes;
   logic [3:0]   rd_len;

   assign acc      = req_valid && req_ready;
   assign tab_take = acc && !req_func;

   fsst8_loader #(
      .MAX_SYMBOL_LEN(MAX_SYMBOL_LEN), .MAX_SYMBOLS(MAX_SYMBOLS),
      .MAX_BODY_BYTES(MAX_BODY_BYTES)
   ) u_loader (
      .clock(clock), .reset(reset), .take(tab_take), .in_byte(req_in_byte),
      .last(req_last), .wr(wr), .done(ld_done), .done_status(ld_status),
      .table_valid(tab_valid), .symbol_total(sym_total)
   );

   // stage one: classify value byte, issue store read
   logic esc_ff, esc_in;
   logic s1_v_ff, s1_v_in;          // result expected
   logic s1_sym_ff, s1_sym_in;      // result comes from store
   logic [W-1:0] s1_bytes_ff, s1_bytes_in;
   logic [3:0]   s1_cnt_ff, s1_cnt_in;
   logic [2:0]   s1_st_ff, s1_st_in;
   logic s1_tab_ff, s1_tab_in, s1_eov_ff, s1_eov_in;
   logic rd_en;

   always_comb begin
      esc_in      = esc_ff;
      s1_v_in     = 1'b0;
      s1_sym_in   = 1'b0;
      s1_bytes_in = '0;
      s1_cnt_in   = '0;
      s1_st_in    = fsst8_pkg::ST_OK;
      s1_tab_in   = 1'b0;
      s1_eov_in   = req_last;
      rd_en       = 1'b0;
      if (acc) begin
         if (!req_func) begin
            s1_v_in   = ld_done;
            s1_st_in  = ld_status;
            s1_tab_in = 1'b1;
            s1_eov_in = 1'b1;
         end else begin
            s1_v_in = 1'b1;
            if (!tab_valid) begin
               esc_in   = 1'b0;
               s1_st_in = fsst8_pkg::ST_NOTAB;
            end else if (esc_ff) begin
               esc_in      = 1'b0;
               s1_bytes_in = W'(req_in_byte);
               s1_cnt_in   = 4'd1;
            end else if (req_in_byte == fsst8_pkg::ESC_CODE) begin
               if (!req_last) begin
                  esc_in  = 1'b1;
                  s1_v_in = 1'b0;
               end else begin
                  s1_st_in = fsst8_pkg::ST_TRUNC;
               end
            end else if (req_in_byte >= sym_total ||
                         9'(req_in_byte) >= 9'(MAX_SYMBOLS)) begin
               s1_st_in = fsst8_pkg::ST_CODE;
            end else begin
               s1_sym_in = 1'b1;
               rd_en     = 1'b1;
            end
            if (req_last) esc_in = 1'b0;
         end
      end
   end

   fsst8_store #(.MAX_SYMBOL_LEN(MAX_SYMBOL_LEN), .MAX_SYMBOLS(MAX_SYMBOLS)) u_store (
      .clock(clock), .wr(wr), .rd_en(rd_en), .rd_addr(req_in_byte),
      .rd_bytes(rd_bytes), .rd_len(rd_len)
   );

   // stage two: pick data, mask by length, length limit check
   logic [31:0] dlen_ff, dlen_in;
   logic [W-1:0] r_bytes;
   logic [3:0]   r_cnt;
   logic [2:0]   r_st;

   always_comb begin
      dlen_in = dlen_ff;
      r_bytes = s1_bytes_ff;
      r_cnt   = s1_cnt_ff;
      r_st    = s1_st_ff;
      if (s1_sym_ff) begin
         r_cnt = rd_len;
         for (int l = 0; l < MAX_SYMBOL_LEN; l++)
            r_bytes[8*l +: 8] = (4'(l) < rd_len) ? rd_bytes[8*l +: 8] : 8'd0;
      end
      if (s1_v_ff && !s1_tab_ff) begin
         if (r_cnt != 4'd0) begin
            if (dlen_ff > 32'h7FFF_FFFF - 32'(r_cnt)) begin
               r_st    = fsst8_pkg::ST_LONG;
               r_bytes = '0;
               r_cnt   = '0;
            end else begin
               dlen_in = dlen_ff + 32'(r_cnt);
            end
         end
         if (s1_eov_ff) dlen_in = '0;
      end
   end

   // three-entry output queue, entry zero drives rsp
   typedef struct packed {
      logic [W-1:0] bytes;
      logic [3:0]   cnt;
      logic [2:0]   st;
      logic         tab;
      logic         eov;
   } rsp_type;

   rsp_type q_ff [QD];
   rsp_type q_in [QD];
   logic [1:0] qn_ff;
   logic [1:0] q_wr;
   logic       pop;
   rsp_type    nr;
   // queue entries plus the item in stage one must fit
   assign req_ready = (32'(qn_ff) + 32'(s1_v_ff)) < 32'(QD);
   assign rsp_valid = (qn_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign q_wr      = qn_ff - 2'(pop);
   assign nr        = '{bytes: r_bytes, cnt: r_cnt, st: r_st, tab: s1_tab_ff, eov: s1_eov_ff};

   assign rsp_out_bytes    = q_ff[0].bytes;
   assign rsp_out_count    = q_ff[0].cnt;
   assign rsp_status       = q_ff[0].st;
   assign rsp_is_table     = q_ff[0].tab;
   assign rsp_end_of_value = q_ff[0].eov;

   always_comb begin
      q_in = q_ff;
      if (pop) begin
         for (int i = 0; i < QD - 1; i++) q_in[i] = q_ff[i + 1];
      end
      if (s1_v_ff) q_in[q_wr] = nr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff  <= 1'b0;
         s1_v_ff <= 1'b0;
         dlen_ff <= '0;
         qn_ff   <= '0;
      end else begin
         esc_ff  <= esc_in;
         s1_v_ff <= s1_v_in;
         dlen_ff <= dlen_in;
         qn_ff   <= qn_ff - 2'(pop) + 2'(s1_v_ff);
      end
      s1_sym_ff   <= s1_sym_in;
      s1_bytes_ff <= s1_bytes_in;
      s1_cnt_ff   <= s1_cnt_in;
      s1_st_ff    <= s1_st_in;
      s1_tab_ff   <= s1_tab_in;
      s1_eov_ff   <= s1_eov_in;
      q_ff        <= q_in;
   end
endmodule

// ===== hw/rtl/fsst8_loader.sv =====
// ----------------------------------------------------------------------------
// fsst8 table loader
// parses the serialized table and places symbol bytes into the store
// ----------------------------------------------------------------------------
module fsst8_loader #(
   parameter int MAX_SYMBOL_LEN = fsst8_pkg::MAX_SYMBOL_LEN,
   parameter int MAX_SYMBOLS    = fsst8_pkg::MAX_SYMBOLS,
   parameter int MAX_BODY_BYTES = fsst8_pkg::MAX_BODY_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            in_byte,
   input  logic                  last,
   output fsst8_pkg::sym_wr_type wr,
   output logic                  done,
   output logic [2:0]            done_status,
   output logic                  table_valid,
   output logic [7:0]            symbol_total
);
   localparam int HDR = 1 + MAX_SYMBOL_LEN;

   logic        active_ff, active_in;
   logic        valid_ff, valid_in;
   logic [7:0]  total_ff, total_in;
   logic [11:0] seen_ff, seen_in;
   logic [10:0] htot_ff, htot_in;
   logic [13:0] exp_ff, exp_in;
   logic [7:0]  hist_ff [MAX_SYMBOL_LEN];
   logic [7:0]  hist_in [MAX_SYMBOL_LEN];
   // place cursor: current length, code, offset and symbols left in this length
   logic [3:0]  clen_ff, clen_in;
   logic [8:0]  ccode_ff, ccode_in;
   logic [2:0]  coff_ff, coff_in;
   logic [7:0]  cleft_ff, cleft_in;
   logic [11:0] pos;
   logic [11:0] seen_nx;
   logic        place_ok;
   logic [3:0]  nlen;
   logic [7:0]  nleft;

   assign table_valid  = valid_ff;
   assign symbol_total = total_ff;

   always_comb begin
      active_in = active_ff;
      valid_in  = valid_ff;
      total_in  = total_ff;
      seen_in   = seen_ff;
      htot_in   = htot_ff;
      exp_in    = exp_ff;
      clen_in   = clen_ff;
      ccode_in  = ccode_ff;
      coff_in   = coff_ff;
      cleft_in  = cleft_ff;
      hist_in   = hist_ff;
      wr        = '0;
      done        = 1'b0;
      done_status = fsst8_pkg::ST_OK;
      pos         = seen_ff;
      seen_nx     = seen_ff;
      place_ok    = 1'b0;
      nlen        = clen_ff;
      nleft       = cleft_ff;
      if (take) begin
         if (!active_ff) begin
            active_in = 1'b1;
            valid_in  = 1'b0;
            pos       = '0;
            htot_in   = '0;
            exp_in    = '0;
            for (int i = 0; i < MAX_SYMBOL_LEN; i++) hist_in[i] = '0;
         end
         if (pos == 12'd0) begin
            total_in = in_byte;
            clen_in  = 4'd1;
            ccode_in = '0;
            coff_in  = '0;
            cleft_in = '0;
         end else if (pos <= 12'(MAX_SYMBOL_LEN)) begin
            hist_in[3'(pos[3:0] - 4'd1)] = in_byte;
            htot_in = htot_in + 11'(in_byte);
            exp_in  = exp_in + 14'(in_byte) * 14'(pos[3:0]);
            if (pos == 12'd1) cleft_in = in_byte;
         end else if (pos < 12'd4095) begin
            // jump to the next length that still has symbols
            if (cleft_in == 8'd0 && coff_in == 3'd0) begin
               nlen  = 4'(MAX_SYMBOL_LEN);
               nleft = 8'd0;
               for (int k = MAX_SYMBOL_LEN; k >= 1; k--) begin
                  if (4'(k) > clen_in && hist_ff[3'(k - 1)] != 8'd0) begin
                     nlen  = 4'(k);
                     nleft = hist_ff[3'(k - 1)];
                  end
               end
               clen_in  = nlen;
               cleft_in = nleft;
            end
            place_ok = (cleft_in != 8'd0);
            if (place_ok) begin
               wr.en   = (ccode_in < 9'(MAX_SYMBOLS));
               wr.code = ccode_in[7:0];
               wr.off  = coff_in;
               wr.len  = clen_in;
               wr.data = in_byte;
               if (4'(coff_in) == clen_in - 4'd1) begin
                  coff_in  = '0;
                  ccode_in = ccode_in + 9'd1;
                  cleft_in = cleft_in - 8'd1;
               end else begin
                  coff_in = coff_in + 3'd1;
               end
            end
         end
         seen_nx = (pos != 12'd4095) ? pos + 12'd1 : pos;
         seen_in = seen_nx;
         if (last) begin
            done = 1'b1;
            if (seen_nx < 12'(HDR) || seen_nx > 12'(MAX_BODY_BYTES))
               done_status = fsst8_pkg::ST_BODY;
            else if (htot_in != 11'(total_in))
               done_status = fsst8_pkg::ST_HIST;
            else if (exp_in != 14'(seen_nx - 12'(HDR)))
               done_status = fsst8_pkg::ST_DATA;
            else
               done_status = fsst8_pkg::ST_OK;
            valid_in  = (done_status == fsst8_pkg::ST_OK);
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         total_ff  <= '0;
         seen_ff   <= '0;
         htot_ff   <= '0;
         exp_ff    <= '0;
         clen_ff   <= 4'd1;
         ccode_ff  <= '0;
         coff_ff   <= '0;
         cleft_ff  <= '0;
         for (int i = 0; i < MAX_SYMBOL_LEN; i++) hist_ff[i] <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         total_ff  <= total_in;
         seen_ff   <= seen_in;
         htot_ff   <= htot_in;
         exp_ff    <= exp_in;
         clen_ff   <= clen_in;
         ccode_ff  <= ccode_in;
         coff_ff   <= coff_in;
         cleft_ff  <= cleft_in;
         hist_ff   <= hist_in;
      end
   end
endmodule

// ===== hw/rtl/fsst8_store.sv =====
// ----------------------------------------------------------------------------
// fsst8 symbol store
// per-byte-lane symbol memory with one registered read port
// ----------------------------------------------------------------------------
module fsst8_store #(
   parameter int MAX_SYMBOL_LEN = fsst8_pkg::MAX_SYMBOL_LEN,
   parameter int MAX_SYMBOLS    = fsst8_pkg::MAX_SYMBOLS
) (
   input  logic                        clock,
   input  fsst8_pkg::sym_wr_type       wr,
   input  logic                        rd_en,
   input  logic [7:0]                  rd_addr,
   output logic [8*MAX_SYMBOL_LEN-1:0] rd_bytes,
   output logic [3:0]                  rd_len
);
   logic [7:0] lane_mem [MAX_SYMBOL_LEN][MAX_SYMBOLS];
   logic [3:0] len_mem  [MAX_SYMBOLS];

   // offset zero restarts the symbol: upper lanes read as zero by length mask
   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int l = 0; l < MAX_SYMBOL_LEN; l++) begin
            if (3'(l) == wr.off) lane_mem[l][wr.code] <= wr.data;
         end
         if (wr.off == 3'd0) len_mem[wr.code] <= wr.len;
      end
      if (rd_en) begin
         for (int l = 0; l < MAX_SYMBOL_LEN; l++) rd_bytes[8*l +: 8] <= lane_mem[l][rd_addr];
         rd_len <= len_mem[rd_addr];
      end
   end
endmodule
